### src/assert_macros.svh
// Assertion macros used by the allocator controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SCBA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SCBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/scba_pkg.sv
// Shared types and constants of the size-class block allocator.
`default_nettype none

package scba_pkg;

   localparam int NUM_CLASSES     = 5;
   localparam int SLOTS_PER_CLASS = 8;
   localparam int CLASS_W         = 3;
   localparam int SLOT_W          = $clog2(SLOTS_PER_CLASS);
   localparam int SIZE_W          = 16;
   localparam int BYTES_W         = 9;
   localparam int LINK_W          = SLOT_W + 1;
   localparam int LINK_DEPTH      = NUM_CLASSES * SLOTS_PER_CLASS;
   localparam int ADDR_W          = CLASS_W + SLOT_W;

   // Block size of each class in bytes.
   localparam logic [BYTES_W-1:0] CLASS_BYTES [NUM_CLASSES] =
      '{9'd16, 9'd32, 9'd64, 9'd128, 9'd256};

   // Request operation codes.
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_POST
   } scba_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic pop;
      logic load_out;
   } scba_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic alloc_hit;
   } scba_stat_type;

endpackage

`default_nettype wire

### src/scba_dp.sv
// Datapath of the allocator: list heads, link memory and result registers.
`default_nettype none

module scba_dp
   import scba_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire scba_cmd_type        cmd,
   output      scba_stat_type       stat,
   input  wire logic                req_cmd,
   input  wire logic [SIZE_W-1:0]   req_size,
   input  wire logic [CLASS_W-1:0]  req_free_class,
   input  wire logic [SLOT_W-1:0]   req_free_slot,
   output      logic                rsp_ok,
   output      logic [CLASS_W-1:0]  rsp_grant_class,
   output      logic [SLOT_W-1:0]   rsp_grant_slot
);

   logic [SLOT_W-1:0]      head_slot_ff [NUM_CLASSES];
   logic [NUM_CLASSES-1:0] head_nil_ff;
   logic [LINK_W-1:0]      link_mem [LINK_DEPTH];
   logic [LINK_DEPTH-1:0]  link_vld_ff;
   logic [LINK_W-1:0]      link_rd_ff;
   logic                   rd_vld_ff;
   logic [CLASS_W-1:0]     pop_class_ff;
   logic [SLOT_W-1:0]      pop_slot_ff;
   logic                   res_ok_ff;
   logic [CLASS_W-1:0]     res_class_ff;
   logic [SLOT_W-1:0]      res_slot_ff;
   logic                   out_ok_ff;
   logic [CLASS_W-1:0]     out_class_ff;
   logic [SLOT_W-1:0]      out_slot_ff;

   logic [NUM_CLASSES-1:0] cand;
   logic [CLASS_W-1:0]     sel_class;
   logic                   alloc_hit;
   logic                   free_ok;
   logic                   mem_we;
   logic                   mem_re;
   logic [ADDR_W-1:0]      wr_addr;
   logic [ADDR_W-1:0]      rd_addr;
   logic [LINK_W-1:0]      next_link;

   // A class is a candidate when its blocks fit the size and its list is not empty.
   always_comb begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
         cand[c] = (req_size <= {{(SIZE_W-BYTES_W){1'b0}}, CLASS_BYTES[c]}) &&
                   !head_nil_ff[c];
      end
   end

   // The smallest candidate class wins.
   always_comb begin
      sel_class = '0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (cand[c]) begin
            sel_class = CLASS_W'(c);
         end
      end
   end

   assign alloc_hit = (req_cmd == CMD_ALLOC) && (|cand);
   assign free_ok   = (req_cmd == CMD_FREE) &&
                      (req_free_class < CLASS_W'(NUM_CLASSES));
   assign stat.alloc_hit = alloc_hit;

   assign mem_we  = cmd.accept && free_ok;
   assign mem_re  = cmd.accept && alloc_hit;
   assign wr_addr = {req_free_class, req_free_slot};
   assign rd_addr = {sel_class, head_slot_ff[sel_class]};

   // Link memory: a free writes the old head, an allocate reads the head's link.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[wr_addr] <= {head_nil_ff[req_free_class], head_slot_ff[req_free_class]};
      end
      if (mem_re) begin
         link_rd_ff   <= link_mem[rd_addr];
         rd_vld_ff    <= link_vld_ff[rd_addr];
         pop_class_ff <= sel_class;
         pop_slot_ff  <= head_slot_ff[sel_class];
      end
   end

   // Entries never written read as the chained order set up at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         link_vld_ff <= '0;
      end else if (mem_we) begin
         link_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // Link of the popped slot, from memory or from the reset chain.
   always_comb begin
      if (rd_vld_ff) begin
         next_link = link_rd_ff;
      end else if (pop_slot_ff == SLOT_W'(SLOTS_PER_CLASS - 1)) begin
         next_link = {1'b1, {SLOT_W{1'b0}}};
      end else begin
         next_link = {1'b0, pop_slot_ff + SLOT_W'(1)};
      end
   end

   // List heads: a free pushes at once, an allocate pops once the link is read.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_nil_ff <= '0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_slot_ff[c] <= '0;
         end
      end else if (mem_we) begin
         head_nil_ff[req_free_class]  <= 1'b0;
         head_slot_ff[req_free_class] <= req_free_slot;
      end else if (cmd.pop) begin
         head_nil_ff[pop_class_ff]  <= next_link[LINK_W-1];
         head_slot_ff[pop_class_ff] <= next_link[SLOT_W-1:0];
      end
   end

   // Result of the accepted request, held until the output register is free.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         res_ok_ff    <= alloc_hit || free_ok;
         res_class_ff <= alloc_hit ? sel_class : '0;
         res_slot_ff  <= alloc_hit ? head_slot_ff[sel_class] : '0;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_ok_ff    <= res_ok_ff;
         out_class_ff <= res_class_ff;
         out_slot_ff  <= res_slot_ff;
      end
   end

   assign rsp_ok          = out_ok_ff;
   assign rsp_grant_class = out_class_ff;
   assign rsp_grant_slot  = out_slot_ff;

endmodule

`default_nettype wire

### src/scba_ctrl.sv
// Controller of the allocator: request sequencing and the response handshake.
`default_nettype none

`include "assert_macros.svh"

module scba_ctrl
   import scba_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output      logic           req_ready,
   output      logic           rsp_valid,
   input  wire logic           rsp_ready,
   input  wire scba_stat_type  stat,
   output      scba_cmd_type   cmd
);

   scba_state_type state_ff;
   scba_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           req_fire;
   logic           out_free;

   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = stat.alloc_hit ? ST_POP : ST_POST;
            end
         end
         ST_POP: begin
            state_in = ST_POST;
         end
         ST_POST: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      req_ready    = 1'b0;
      cmd.accept   = 1'b0;
      cmd.pop      = 1'b0;
      cmd.load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_POP: begin
            cmd.pop = 1'b1;
         end
         ST_POST: begin
            cmd.load_out = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Response valid flag beside the output register.
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `SCBA_ASSERT_NEXT(a_hit_pops, clock, reset, req_fire && stat.alloc_hit, state_ff == ST_POP, "allocate hit did not pop")
   `SCBA_ASSERT_NEXT(a_pop_posts, clock, reset, state_ff == ST_POP, state_ff == ST_POST, "pop not followed by result")
   `SCBA_ASSERT_NEXT(a_post_shows, clock, reset, cmd.load_out, rsp_valid_ff && (state_ff == ST_IDLE), "result not presented")

endmodule

`default_nettype wire

### src/size_class_block_allocator.sv
// Size-class block allocator: five LIFO free lists of 16 to 256 byte blocks.
// An allocate that pops a list goes through ST_POP and ST_POST after the request
// is accepted; a free or a failed allocate goes straight to ST_POST.
// A new request is taken only in ST_IDLE, once the last one has gone through the
// registered link read and its response hand-over to a free output register.
// Reset: every list head returns to slot 0 and all link entries read as the
// slot-order chain again at once (per-entry valid bits), with no clearing pass.
`default_nettype none

module size_class_block_allocator
   import scba_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic                req_cmd,
   input  wire logic [SIZE_W-1:0]   req_size,
   input  wire logic [CLASS_W-1:0]  req_free_class,
   input  wire logic [SLOT_W-1:0]   req_free_slot,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic                rsp_ok,
   output      logic [CLASS_W-1:0]  rsp_grant_class,
   output      logic [SLOT_W-1:0]   rsp_grant_slot
);

   scba_cmd_type  cmd;
   scba_stat_type stat;

   scba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   scba_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_cmd         (req_cmd),
      .req_size        (req_size),
      .req_free_class  (req_free_class),
      .req_free_slot   (req_free_slot),
      .rsp_ok          (rsp_ok),
      .rsp_grant_class (rsp_grant_class),
      .rsp_grant_slot  (rsp_grant_slot)
   );

endmodule

`default_nettype wire
